### design/sit_pkg.sv
// ----------------------------------------------------------------------------
// sit_pkg: shared constants for the segment intersection test
// index maps for the coordinate differences and the product terms
// ----------------------------------------------------------------------------
package sit_pkg;

	// coordinate differences after endpoint ordering
	localparam int unsigned N_DIFF = 10;
	localparam int unsigned D_AX  = 0;  // a1x - a0x
	localparam int unsigned D_AY  = 1;  // a1y - a0y
	localparam int unsigned D_BX  = 2;  // b1x - b0x
	localparam int unsigned D_BY  = 3;  // b1y - b0y
	localparam int unsigned D_E0X = 4;  // b0x - a0x
	localparam int unsigned D_E0Y = 5;  // b0y - a0y
	localparam int unsigned D_E1X = 6;  // b1x - a0x
	localparam int unsigned D_E1Y = 7;  // b1y - a0y
	localparam int unsigned D_F1X = 8;  // a1x - b0x
	localparam int unsigned D_F1Y = 9;  // a1y - b0y

	// product terms, pairs (2k, 2k+1) form one orientation or the dot product
	localparam int unsigned N_PROD  = 10;
	localparam int unsigned N_ORIENT = 4;
	localparam int unsigned P_DOTA = 8;
	localparam int unsigned P_DOTB = 9;

	localparam int unsigned PROD_L [N_PROD] = '{
		D_E0X, D_AX,   // orientation of b0 against a
		D_E1X, D_AX,   // orientation of b1 against a
		D_BX,  D_E0X,  // orientation of a0 against b
		D_F1X, D_BX,   // orientation of a1 against b
		D_E1X, D_E1Y   // gap vector dot product
	};
	localparam int unsigned PROD_R [N_PROD] = '{
		D_AY,  D_E0Y,
		D_AY,  D_E1Y,
		D_E0Y, D_BY,
		D_BY,  D_F1Y,
		D_F1X, D_F1Y
	};

endpackage

### design/segment_intersection_test.sv
// ----------------------------------------------------------------------------
// segment_intersection_test: proper crossing test for two 2D segments
// four-stage pipeline; without output stalls, one segment pair per clock
// ----------------------------------------------------------------------------
// Takes one pair of segments per beat and returns one crosses beat per pair,
// in order. Throughput is one pair per cycle while the output side is not
// stalled. Each beat moves through the input register, the difference
// register, the product register and then the result register, which
// presents it. The depth is set by the ten signed multipliers, which sit
// alone between the difference and product registers. Each stage holds its
// data while the stage after it is full and stalled, so input beats keep
// flowing until the whole pipeline is full. crosses is 1 for a proper
// crossing, or for a collinear pair that truly overlaps; a touch at one
// endpoint gives 0.
// ----------------------------------------------------------------------------
module segment_intersection_test #(
	parameter int unsigned COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] a_start_x,
	input  logic signed [COORD_BITS-1:0] a_start_y,
	input  logic signed [COORD_BITS-1:0] a_stop_x,
	input  logic signed [COORD_BITS-1:0] a_stop_y,
	input  logic signed [COORD_BITS-1:0] b_start_x,
	input  logic signed [COORD_BITS-1:0] b_start_y,
	input  logic signed [COORD_BITS-1:0] b_stop_x,
	input  logic signed [COORD_BITS-1:0] b_stop_y,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         crosses
);

	localparam int unsigned DW = COORD_BITS + 1;
	localparam int unsigned PW = 2 * DW;

	// stage 1: input beat as received
	logic signed [COORD_BITS-1:0] a_start_x_s1, a_start_y_s1, a_stop_x_s1, a_stop_y_s1;
	logic signed [COORD_BITS-1:0] b_start_x_s1, b_start_y_s1, b_stop_x_s1, b_stop_y_s1;
	logic valid_s1;

	// stage 2: ordered endpoint differences
	logic signed [DW-1:0] diff_d  [sit_pkg::N_DIFF];
	logic signed [DW-1:0] diff_s2 [sit_pkg::N_DIFF];
	logic valid_s2;

	// stage 3: product terms
	logic signed [PW-1:0] prod_d  [sit_pkg::N_PROD];
	logic signed [PW-1:0] prod_s3 [sit_pkg::N_PROD];
	logic valid_s3;

	// result register
	logic crosses_d, crosses_q, out_valid_q;

	// load enables: a stage takes new data when it is empty or its data moves on
	logic load_out, load_s3, load_s2, load_s1;

	assign load_out = !out_valid_q || out_ready;
	assign load_s3  = !valid_s3 || load_out;
	assign load_s2  = !valid_s2 || load_s3;
	assign load_s1  = !valid_s1 || load_s2;
	assign in_ready = load_s1;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_s1)  valid_s1    <= in_valid;
			if (load_s2)  valid_s2    <= valid_s1;
			if (load_s3)  valid_s3    <= valid_s2;
			if (load_out) out_valid_q <= valid_s3;
		end
	end

	// payload registers, loaded only with a live beat
	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			a_start_x_s1 <= a_start_x;
			a_start_y_s1 <= a_start_y;
			a_stop_x_s1  <= a_stop_x;
			a_stop_y_s1  <= a_stop_y;
			b_start_x_s1 <= b_start_x;
			b_start_y_s1 <= b_start_y;
			b_stop_x_s1  <= b_stop_x;
			b_stop_y_s1  <= b_stop_y;
		end
		if (load_s2 && valid_s1) begin
			diff_s2 <= diff_d;
		end
		if (load_s3 && valid_s2) begin
			prod_s3 <= prod_d;
		end
		if (load_out && valid_s3) begin
			crosses_q <= crosses_d;
		end
	end

	sit_order_diff #(
		.COORD_BITS(COORD_BITS)
	) u_order_diff (
		.a_start_x(a_start_x_s1),
		.a_start_y(a_start_y_s1),
		.a_stop_x (a_stop_x_s1),
		.a_stop_y (a_stop_y_s1),
		.b_start_x(b_start_x_s1),
		.b_start_y(b_start_y_s1),
		.b_stop_x (b_stop_x_s1),
		.b_stop_y (b_stop_y_s1),
		.diff     (diff_d)
	);

	sit_mul #(
		.COORD_BITS(COORD_BITS)
	) u_mul (
		.diff(diff_s2),
		.prod(prod_d)
	);

	sit_decide #(
		.COORD_BITS(COORD_BITS)
	) u_decide (
		.prod   (prod_s3),
		.crosses(crosses_d)
	);

	assign out_valid = out_valid_q;
	assign crosses   = crosses_q;

endmodule

### design/sit_order_diff.sv
// ----------------------------------------------------------------------------
// sit_order_diff: endpoint ordering and coordinate differences
// orders each segment by x then y and forms the ten difference terms
// ----------------------------------------------------------------------------
module sit_order_diff #(
	parameter int unsigned COORD_BITS = 16
) (
	input  logic signed [COORD_BITS-1:0] a_start_x,
	input  logic signed [COORD_BITS-1:0] a_start_y,
	input  logic signed [COORD_BITS-1:0] a_stop_x,
	input  logic signed [COORD_BITS-1:0] a_stop_y,
	input  logic signed [COORD_BITS-1:0] b_start_x,
	input  logic signed [COORD_BITS-1:0] b_start_y,
	input  logic signed [COORD_BITS-1:0] b_stop_x,
	input  logic signed [COORD_BITS-1:0] b_stop_y,
	output logic signed [COORD_BITS:0]   diff [sit_pkg::N_DIFF]
);

	localparam int unsigned DW = COORD_BITS + 1;

	logic signed [COORD_BITS:0] a0x, a0y, a1x, a1y, b0x, b0y, b1x, b1y;
	logic a_keep, b_keep;

	// keep the given order when start is the lesser point
	assign a_keep = (a_start_x < a_stop_x) ||
		((a_start_x == a_stop_x) && (a_start_y < a_stop_y));
	assign b_keep = (b_start_x < b_stop_x) ||
		((b_start_x == b_stop_x) && (b_start_y < b_stop_y));

	always_comb begin
		if (a_keep) begin
			a0x = DW'(a_start_x); a0y = DW'(a_start_y);
			a1x = DW'(a_stop_x);  a1y = DW'(a_stop_y);
		end else begin
			a0x = DW'(a_stop_x);  a0y = DW'(a_stop_y);
			a1x = DW'(a_start_x); a1y = DW'(a_start_y);
		end
		if (b_keep) begin
			b0x = DW'(b_start_x); b0y = DW'(b_start_y);
			b1x = DW'(b_stop_x);  b1y = DW'(b_stop_y);
		end else begin
			b0x = DW'(b_stop_x);  b0y = DW'(b_stop_y);
			b1x = DW'(b_start_x); b1y = DW'(b_start_y);
		end
	end

	// one extra bit keeps every difference exact
	assign diff[sit_pkg::D_AX]  = a1x - a0x;
	assign diff[sit_pkg::D_AY]  = a1y - a0y;
	assign diff[sit_pkg::D_BX]  = b1x - b0x;
	assign diff[sit_pkg::D_BY]  = b1y - b0y;
	assign diff[sit_pkg::D_E0X] = b0x - a0x;
	assign diff[sit_pkg::D_E0Y] = b0y - a0y;
	assign diff[sit_pkg::D_E1X] = b1x - a0x;
	assign diff[sit_pkg::D_E1Y] = b1y - a0y;
	assign diff[sit_pkg::D_F1X] = a1x - b0x;
	assign diff[sit_pkg::D_F1Y] = a1y - b0y;

endmodule

### design/sit_mul.sv
// ----------------------------------------------------------------------------
// sit_mul: product terms
// ten signed multipliers, one per product term of the orientation and overlap tests
// ----------------------------------------------------------------------------
module sit_mul #(
	parameter int unsigned COORD_BITS = 16
) (
	input  logic signed [COORD_BITS:0]       diff [sit_pkg::N_DIFF],
	output logic signed [2*COORD_BITS+1:0]   prod [sit_pkg::N_PROD]
);

	localparam int unsigned PW = 2 * COORD_BITS + 2;

	for (genvar g = 0; g < sit_pkg::N_PROD; g++) begin : g_prod
		assign prod[g] = PW'(diff[sit_pkg::PROD_L[g]]) * PW'(diff[sit_pkg::PROD_R[g]]);
	end

endmodule

### design/sit_decide.sv
// ----------------------------------------------------------------------------
// sit_decide: crossing decision
// forms orientation signs and the collinear overlap test from the products
// ----------------------------------------------------------------------------
module sit_decide #(
	parameter int unsigned COORD_BITS = 16
) (
	input  logic signed [2*COORD_BITS+1:0] prod [sit_pkg::N_PROD],
	output logic                           crosses
);

	localparam int unsigned PW = 2 * COORD_BITS + 2;
	localparam int unsigned SW = PW + 1;

	logic signed [SW-1:0] orient_sum [sit_pkg::N_ORIENT];
	logic signed [SW-1:0] dot_sum;
	logic [sit_pkg::N_ORIENT-1:0] is_zero, is_neg;
	logic dot_pos;

	for (genvar k = 0; k < sit_pkg::N_ORIENT; k++) begin : g_orient
		assign orient_sum[k] = SW'(prod[2*k]) - SW'(prod[2*k+1]);
		assign is_zero[k]    = (orient_sum[k] == '0);
		assign is_neg[k]     = orient_sum[k][SW-1];
	end

	// gap vectors opposite when their dot product is negative
	assign dot_sum = SW'(prod[sit_pkg::P_DOTA]) + SW'(prod[sit_pkg::P_DOTB]);
	assign dot_pos = !dot_sum[SW-1] && (dot_sum != '0);

	always_comb begin
		if (&is_zero) begin
			crosses = dot_pos;
		end else if (is_zero[0] || is_zero[1]) begin
			crosses = 1'b0;
		end else begin
			crosses = (is_neg[0] != is_neg[1]) && !is_zero[2] && !is_zero[3] &&
				(is_neg[2] != is_neg[3]);
		end
	end

endmodule

### design/sit_checker.sv
// ----------------------------------------------------------------------------
// sit_checker: port-level checks for segment_intersection_test
// handshake and flow-control checks, bound to the top level
// ----------------------------------------------------------------------------
module sit_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic crosses
);

	// a stalled result beat stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	// a stalled result beat keeps its value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(crosses))
		else $error("result beat changed while stalled");

	// no back-pressure on the input while the output side takes beats
	a_ready_flow: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output is ready");

	// an empty result register never stalls the input
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with no pending result");

	// no result without an earlier input beat right after reset
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("result beat without input");

endmodule

bind segment_intersection_test sit_checker u_sit_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.crosses  (crosses)
);
